>>> design/assert_macros.svh
// Assertion macros shared by the ring record allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define RRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rra assertion failed");
`define RRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rra assertion failed");
`else
`define RRA_ASSERT(lbl, clk, rst_n, prop)
`define RRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/rra_pkg.sv
// Types and constants of the ring record allocator
package rra_pkg;

    localparam int LEN_W  = 17;
    localparam int OFF_W  = 16;
    localparam int USED_W = 17;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_SHRINK = 2'd1;
    localparam logic [1:0] ACT_FREE   = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_SHRINK = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_SPACE = 2'd1,
        STS_NOT_END  = 2'd2,
        STS_GROW     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_LOAD = 2'b10
    } t_back_state;

    typedef struct packed {
        logic [1:0]       action;
        logic [OFF_W-1:0] request_bytes;
        logic [OFF_W-1:0] record_offset;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  payload_offset;
        logic [USED_W-1:0] used_bytes;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] offset;
    } t_cmd;

endpackage

>>> design/rra_ram.sv
// Generic single-write, single-read RAM with registered read data
module rra_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rra_queue.sv
// Two-entry queue between allocator stages
`include "assert_macros.svh"

module rra_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];

    `RRA_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 2'd2)
    `RRA_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop))
    `RRA_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))

endmodule

>>> design/rra_front.sv
// Request intake: decodes the action and rounds the record size
module rra_front
    import rra_pkg::*;
#(
    parameter int ALIGN_BYTES  = 32,
    parameter int HEADER_BYTES = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_request i_request,
    output logic     o_cmd_vld,
    output t_cmd     o_cmd,
    input  logic     i_cmd_rdy
);

    localparam int ALIGN_L  = $clog2(ALIGN_BYTES);
    localparam int SHIFT    = LEN_W + ALIGN_L;
    localparam int RECIP_M  = ((2 ** SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PROD_W   = 2 * LEN_W + 1;

    logic             r_vld;
    logic [LEN_W-1:0] r_q;
    t_op              r_op;
    logic [OFF_W-1:0] r_off;

    logic             accept;
    logic [LEN_W-1:0] sum;
    logic [PROD_W-1:0] prod;
    t_op              op;

    assign accept = i_push && !o_full;
    assign o_full = r_vld && !i_cmd_rdy;

    // size + header + align - 1, divided by the alignment via reciprocal
    assign sum  = LEN_W'(i_request.request_bytes) + LEN_W'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign prod = PROD_W'(sum) * PROD_W'(RECIP_M);

    always_comb begin
        unique case (i_request.action)
            ACT_ALLOC:  op = OP_ALLOC;
            ACT_SHRINK: op = OP_SHRINK;
            ACT_FREE:   op = OP_FREE;
            default:    op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_cmd_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q   <= LEN_W'(prod >> SHIFT);
            r_op  <= op;
            r_off <= i_request.record_offset;
        end
    end

    assign o_cmd_vld  = r_vld;
    assign o_cmd.op     = r_op;
    assign o_cmd.len    = LEN_W'(r_q * LEN_W'(ALIGN_BYTES));
    assign o_cmd.offset = r_off;

endmodule

>>> design/rra_back.sv
// Execution unit: ring bookkeeping and the record table
`include "assert_macros.svh"

module rra_back
    import rra_pkg::*;
#(
    parameter int BUF_BYTES    = 65536,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_RECORDS  = 2048
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_vld,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_rdy,
    output logic    o_res_push,
    output t_result o_result
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int SA_W  = $clog2(BUF_BYTES + 1);
    localparam int SUM_W = ((SA_W > LEN_W) ? SA_W : LEN_W) + 1;

    typedef struct packed {
        logic [SA_W-1:0]  start;
        logic [LEN_W-1:0] len;
    } t_entry;

    t_back_state       r_state, n_state;
    logic              r_load_old, n_load_old;
    logic [IDX_W-1:0]  r_old_idx, n_old_idx;
    logic [IDX_W-1:0]  r_new_idx, n_new_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [USED_W-1:0] r_used, n_used;
    t_entry            r_old, n_old;
    t_entry            r_new, n_new;

    logic              fire;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_entry            wdata;
    logic [IDX_W-1:0]  raddr;
    t_entry            rdata;
    logic [SUM_W-1:0]  cand;
    logic [SUM_W-1:0]  fit;
    logic              ok;
    logic [SA_W-1:0]   place;
    logic [IDX_W-1:0]  slot;
    t_entry            ent;
    t_status           status;
    logic [OFF_W-1:0]  payload;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] i);
        f_next = (i == IDX_W'(MAX_RECORDS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] i);
        f_prev = (i == '0) ? IDX_W'(MAX_RECORDS - 1) : i - 1'b1;
    endfunction

    function automatic logic f_names(input t_entry e, input logic [OFF_W-1:0] off);
        f_names = ((OFF_W'(e.start) + OFF_W'(HEADER_BYTES)) == off);
    endfunction

    rra_ram #(
        .W     ($bits(t_entry)),
        .DEPTH (MAX_RECORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign fire = (r_state == S_EXEC) && i_cmd_vld && i_res_rdy;
    assign cand = SUM_W'(r_new.start) + SUM_W'(r_new.len);
    assign fit  = cand + SUM_W'(i_cmd.len);

    // placement: after the newest record, or wrapped to offset zero
    always_comb begin
        ok    = 1'b0;
        place = '0;
        if (r_count == CNT_W'(MAX_RECORDS)) begin
            ok = 1'b0;
        end else if (r_count == '0) begin
            ok = (SUM_W'(i_cmd.len) <= SUM_W'(BUF_BYTES));
        end else if (r_old.start > r_new.start) begin
            ok    = (fit <= SUM_W'(r_old.start));
            place = SA_W'(cand);
        end else if (fit <= SUM_W'(BUF_BYTES)) begin
            ok    = 1'b1;
            place = SA_W'(cand);
        end else if (SUM_W'(i_cmd.len) < SUM_W'(r_old.start)) begin
            ok = 1'b1;
        end
        slot      = (r_count == '0) ? r_old_idx : f_next(r_new_idx);
        ent.start = place;
        ent.len   = i_cmd.len;
    end

    always_comb begin
        n_state    = r_state;
        n_load_old = r_load_old;
        n_old_idx  = r_old_idx;
        n_new_idx  = r_new_idx;
        n_count    = r_count;
        n_used     = r_used;
        n_old      = r_old;
        n_new      = r_new;
        we         = 1'b0;
        waddr      = r_new_idx;
        wdata      = r_new;
        raddr      = f_next(r_old_idx);
        status     = STS_OK;
        payload    = '0;
        unique case (r_state)
            S_EXEC: begin
                if (fire) begin
                    case (i_cmd.op)
                        OP_ALLOC: begin
                            if (ok) begin
                                we        = 1'b1;
                                waddr     = slot;
                                wdata     = ent;
                                n_new_idx = slot;
                                n_new     = ent;
                                if (r_count == '0) begin
                                    n_old = ent;
                                end
                                n_count = r_count + 1'b1;
                                n_used  = r_used + USED_W'(i_cmd.len);
                                payload = OFF_W'(place) + OFF_W'(HEADER_BYTES);
                            end else begin
                                status = STS_NO_SPACE;
                            end
                        end
                        OP_SHRINK: begin
                            if (r_count == '0 || !f_names(r_new, i_cmd.offset)) begin
                                status = STS_NOT_END;
                            end else if (i_cmd.len > r_new.len) begin
                                status = STS_GROW;
                            end else begin
                                we          = 1'b1;
                                waddr       = r_new_idx;
                                wdata.start = r_new.start;
                                wdata.len   = i_cmd.len;
                                n_new.len   = i_cmd.len;
                                if (r_count == CNT_W'(1)) begin
                                    n_old.len = i_cmd.len;
                                end
                                n_used = r_used - USED_W'(r_new.len) + USED_W'(i_cmd.len);
                            end
                        end
                        OP_FREE: begin
                            if (r_count == '0) begin
                                status = STS_NOT_END;
                            end else if (f_names(r_old, i_cmd.offset)) begin
                                n_used  = r_used - USED_W'(r_old.len);
                                n_count = r_count - 1'b1;
                                if (r_count == CNT_W'(1)) begin
                                    n_new_idx = r_old_idx;
                                end else if (r_count == CNT_W'(2)) begin
                                    n_old_idx = f_next(r_old_idx);
                                    n_old     = r_new;
                                end else begin
                                    n_old_idx  = f_next(r_old_idx);
                                    raddr      = f_next(r_old_idx);
                                    n_load_old = 1'b1;
                                    n_state    = S_LOAD;
                                end
                            end else if (f_names(r_new, i_cmd.offset)) begin
                                n_used  = r_used - USED_W'(r_new.len);
                                n_count = r_count - 1'b1;
                                if (r_count == CNT_W'(1)) begin
                                    n_old_idx = r_new_idx;
                                end else if (r_count == CNT_W'(2)) begin
                                    n_new_idx = f_prev(r_new_idx);
                                    n_new     = r_old;
                                end else begin
                                    n_new_idx  = f_prev(r_new_idx);
                                    raddr      = f_prev(r_new_idx);
                                    n_load_old = 1'b0;
                                    n_state    = S_LOAD;
                                end
                            end else begin
                                status = STS_NOT_END;
                            end
                        end
                        default: begin
                            status = STS_OK;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (r_load_old) begin
                    n_old = rdata;
                end else begin
                    n_new = rdata;
                end
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_EXEC;
            r_load_old <= 1'b0;
            r_old_idx  <= '0;
            r_new_idx  <= '0;
            r_count    <= '0;
            r_used     <= '0;
        end else begin
            r_state    <= n_state;
            r_load_old <= n_load_old;
            r_old_idx  <= n_old_idx;
            r_new_idx  <= n_new_idx;
            r_count    <= n_count;
            r_used     <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old <= n_old;
        r_new <= n_new;
    end

    assign o_cmd_pop               = fire;
    assign o_res_push              = fire;
    assign o_result.status         = status;
    assign o_result.payload_offset = payload;
    assign o_result.used_bytes     = n_used;

    `RRA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(MAX_RECORDS))
    `RRA_ASSERT(a_single_idx, i_clk, i_rst_n, (r_count > CNT_W'(1)) || (r_old_idx == r_new_idx))
    `RRA_ASSERT_NEXT(a_load_once, i_clk, i_rst_n, r_state == S_LOAD, r_state == S_EXEC)
    `RRA_ASSERT(a_no_fire_load, i_clk, i_rst_n, !(fire && (r_state == S_LOAD)))

endmodule

>>> design/ring_record_allocator_unit.sv
// Ring record allocator: byte-ring space manager for variable-length records
//
// Request channel: push / full with i_request {action, request_bytes,
// record_offset}; a transaction completes when push is high and full is low.
// Result channel: empty / pop with o_result {status, payload_offset,
// used_bytes}; the oldest result is shown while empty is low and leaves when
// pop is high. Every request yields exactly one result, in request order.
// A request passes the intake register, then the command queue; the
// execution unit writes the result queue in the cycle the command leaves.
// Allocate, shrink and most frees are done in the execution state S_EXEC
// alone; freeing the oldest or newest record while three or more are live
// also passes through S_LOAD, which waits on the record table RAM read and
// takes no new command.
// Reset (synchronous, active low) empties both queues and the ring; the
// record table keeps its contents, entries are read only after being written.
// When pop stays low the result queue fills, the execution unit holds, the
// command queue fills and full rises; no result is lost.
module ring_record_allocator_unit
    import rra_pkg::*;
#(
    parameter int BUF_BYTES    = 65536,
    parameter int ALIGN_BYTES  = 32,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_RECORDS  = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_request i_request,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    logic    cmd_vld;
    t_cmd    front_cmd;
    logic    mid_push;
    logic    mid_full;
    logic    mid_empty;
    t_cmd    mid_cmd;
    logic    mid_pop;
    logic    res_push;
    t_result res;
    logic    out_full;
    logic    out_pop;

    rra_front #(
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_request (i_request),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (front_cmd),
        .i_cmd_rdy (!mid_full)
    );

    assign mid_push = cmd_vld && !mid_full;

    rra_queue #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_cmd),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_cmd),
        .o_empty (mid_empty)
    );

    rra_back #(
        .BUF_BYTES    (BUF_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (!mid_empty),
        .i_cmd      (mid_cmd),
        .o_cmd_pop  (mid_pop),
        .i_res_rdy  (!out_full),
        .o_res_push (res_push),
        .o_result   (res)
    );

    assign out_pop = pop && !empty;

    rra_queue #(
        .W ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (out_pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

>>> bench/rra_checker.sv
// Checker for the ring record allocator: predicts each result and compares it
module rra_checker
    import rra_pkg::*;
#(
    parameter int BUF_BYTES    = 65536,
    parameter int ALIGN_BYTES  = 32,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_RECORDS  = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  t_request         i_request,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_result          i_result,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_live_records,
    output logic [OFF_W-1:0] o_oldest_payload,
    output logic [OFF_W-1:0] o_newest_payload
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int SPAN_W = $clog2(BUF_BYTES) + 2;

    logic [SPAN_W-1:0] ring_start [MAX_RECORDS];
    logic [SPAN_W-1:0] ring_span  [MAX_RECORDS];
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [CNT_W-1:0]  live_count;
    logic [USED_W-1:0] bytes_held;
    t_result           results_due [$];
    int                fails = 0;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_live_records   = 0;
        o_oldest_payload = '0;
        o_newest_payload = '0;
    end

    function automatic int unsigned record_span(logic [OFF_W-1:0] bytes);
        return ((32'(bytes) + 32'(HEADER_BYTES + ALIGN_BYTES - 1)) / 32'(ALIGN_BYTES))
               * 32'(ALIGN_BYTES);
    endfunction

    function automatic logic [OFF_W-1:0] payload_of(logic [IDX_W-1:0] idx);
        return OFF_W'(ring_start[idx]) + OFF_W'(HEADER_BYTES);
    endfunction

    function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
        return (i == IDX_W'(MAX_RECORDS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(MAX_RECORDS - 1) : i - 1'b1;
    endfunction

    function automatic t_result apply_request(t_request r);
        t_result          res;
        int unsigned      span, cur, head, tstart, cand, place;
        logic [IDX_W-1:0] slot;
        bit               ok;
        res = '0;
        case (r.action)
            ACT_ALLOC: begin
                span  = record_span(r.request_bytes);
                ok    = 1'b0;
                place = 0;
                if (live_count >= CNT_W'(MAX_RECORDS)) begin
                    ok = 1'b0;
                end else if (live_count == '0) begin
                    ok = (span <= BUF_BYTES);
                end else begin
                    head   = 32'(ring_start[head_idx]);
                    tstart = 32'(ring_start[tail_idx]);
                    cand   = tstart + 32'(ring_span[tail_idx]);
                    if (head > tstart) begin
                        ok    = (cand + span <= head);
                        place = cand;
                    end else if (cand + span <= BUF_BYTES) begin
                        ok    = 1'b1;
                        place = cand;
                    end else if (span < head) begin
                        ok    = 1'b1;
                        place = 0;
                    end
                end
                if (ok) begin
                    slot             = (live_count == '0) ? head_idx : idx_next(tail_idx);
                    ring_start[slot] = SPAN_W'(place);
                    ring_span[slot]  = SPAN_W'(span);
                    tail_idx         = slot;
                    live_count       = live_count + 1'b1;
                    bytes_held       = USED_W'(32'(bytes_held) + span);
                    res.payload_offset = OFF_W'(place + HEADER_BYTES);
                end else begin
                    res.status = STS_NO_SPACE;
                end
            end
            ACT_SHRINK: begin
                if (live_count == '0 || payload_of(tail_idx) != r.record_offset) begin
                    res.status = STS_NOT_END;
                end else begin
                    span = record_span(r.request_bytes);
                    cur  = 32'(ring_span[tail_idx]);
                    if (span > cur) begin
                        res.status = STS_GROW;
                    end else begin
                        ring_span[tail_idx] = SPAN_W'(span);
                        bytes_held          = USED_W'(32'(bytes_held) - (cur - span));
                    end
                end
            end
            ACT_FREE: begin
                if (live_count == '0) begin
                    res.status = STS_NOT_END;
                end else if (payload_of(head_idx) == r.record_offset) begin
                    bytes_held = bytes_held - USED_W'(ring_span[head_idx]);
                    live_count = live_count - 1'b1;
                    if (live_count == '0) tail_idx = head_idx;
                    else head_idx = idx_next(head_idx);
                end else if (payload_of(tail_idx) == r.record_offset) begin
                    bytes_held = bytes_held - USED_W'(ring_span[tail_idx]);
                    live_count = live_count - 1'b1;
                    if (live_count == '0) head_idx = tail_idx;
                    else tail_idx = idx_prev(tail_idx);
                end else begin
                    res.status = STS_NOT_END;
                end
            end
            default: ;
        endcase
        res.used_bytes = bytes_held;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            head_idx   = '0;
            tail_idx   = '0;
            live_count = '0;
            bytes_held = '0;
            results_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d", i_result.status);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (i_result.status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_result.status);
                        fails++;
                    end
                    if (i_result.payload_offset != want.payload_offset) begin
                        $error("payload_offset: expected %0d, actual %0d",
                               want.payload_offset, i_result.payload_offset);
                        fails++;
                    end
                    if (i_result.used_bytes != want.used_bytes) begin
                        $error("used_bytes: expected %0d, actual %0d",
                               want.used_bytes, i_result.used_bytes);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full) results_due.push_back(apply_request(i_request));
        end
        o_fail_count     <= fails;
        o_pending        <= results_due.size();
        o_live_records   <= int'(live_count);
        o_oldest_payload <= (live_count == '0) ? '0 : payload_of(head_idx);
        o_newest_payload <= (live_count == '0) ? '0 : payload_of(tail_idx);
    end

endmodule

>>> bench/tb.sv
// Testbench top for the ring record allocator: stimulus, flow control and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rra_pkg::*;

    localparam int BUF_BYTES    = 65536;
    localparam int ALIGN_BYTES  = 32;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_RECORDS  = 2048;
    localparam int RANDOM_ITEMS = 560;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT        = 400000;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_QUARTER,
        POP_BURSTY
    } t_pop_mode;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_request request = '0;
    logic     full;
    logic     empty;
    t_result  result;

    int               fail_count;
    int               pending;
    int               live_records;
    logic [OFF_W-1:0] oldest_payload;
    logic [OFF_W-1:0] newest_payload;

    bit hold_off    = 1'b0;
    bit steady      = 1'b0;
    int burst_left  = 0;
    int cycle_count = 0;

    ring_record_allocator_unit #(
        .BUF_BYTES   (BUF_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_request(request),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    rra_checker #(
        .BUF_BYTES   (BUF_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_request       (request),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_result        (result),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_live_records  (live_records),
        .o_oldest_payload(oldest_payload),
        .o_newest_payload(newest_payload)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_request make_req(logic [1:0] act, logic [OFF_W-1:0] bytes,
                                          logic [OFF_W-1:0] off);
        t_request r;
        r.action        = act;
        r.request_bytes = bytes;
        r.record_offset = off;
        return r;
    endfunction

    // one request transaction, then the burst/gap bookkeeping
    task automatic offer(t_request r);
        int gap;
        push    <= 1'b1;
        request <= r;
        do @(posedge i_clk); while (full);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_pop_mode mode;
        int        mode_left;
        bit        held;
        mode_left = 0;
        mode      = POP_ALWAYS;
        held      = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_off && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_pop_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_HALF:    pop <= 1'($urandom_range(0, 1));
                    POP_QUARTER: pop <= ($urandom_range(0, 3) == 0);
                    default:     pop <= ((cycle_count % 16) < 8);
                endcase
            end
        end
    end

    initial begin
        t_request         r;
        int               pick;
        logic [OFF_W-1:0] bytes;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, unknown action, oversize and exact-fit allocates
        offer(make_req(ACT_SHRINK, 16'd0, 16'd0));
        offer(make_req(ACT_FREE, 16'd0, 16'd0));
        offer(make_req(ACT_UNKNOWN, 16'hFFFF, 16'hFFFF));
        offer(make_req(ACT_ALLOC, 16'hFFFF, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd65504, 16'hFFFF));
        offer(make_req(ACT_ALLOC, 16'd0, 16'd0));
        offer(make_req(ACT_SHRINK, 16'hFFFF, 16'd32));
        offer(make_req(ACT_SHRINK, 16'd0, 16'd33));
        offer(make_req(ACT_SHRINK, 16'd0, 16'd32));
        offer(make_req(ACT_FREE, 16'd0, 16'd0));
        offer(make_req(ACT_FREE, 16'd0, 16'd32));
        // wrap to zero, exact fit below head, size equal to head start
        offer(make_req(ACT_ALLOC, 16'd30000, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd30000, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd0, 16'd0));
        offer(make_req(ACT_FREE, 16'd0, 16'd30080));
        offer(make_req(ACT_FREE, 16'd0, 16'd32));
        offer(make_req(ACT_ALLOC, 16'd30016, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd10000, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd19968, 16'd0));
        offer(make_req(ACT_ALLOC, 16'd0, 16'd0));
        offer(make_req(ACT_FREE, 16'd0, 16'd10080));
        offer(make_req(ACT_FREE, 16'd0, 16'd30080));
        offer(make_req(ACT_FREE, 16'd0, 16'd32));
        offer(make_req(ACT_FREE, 16'd0, 16'd60128));
        settle();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 200) begin
                hold_off = 1'b1;
                steady   = 1'b1;
            end
            if (i == 400) steady = 1'b0;
            if (i == 450) settle();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 9)) inside
                    0:       bytes = OFF_W'($urandom_range(0, 65535));
                    1:       bytes = $urandom_range(0, 1) ? 16'hFFFF : 16'd65504;
                    [2:3]:   bytes = OFF_W'($urandom_range(0, 12000));
                    default: bytes = OFF_W'($urandom_range(0, 1500));
                endcase
                r = make_req(ACT_ALLOC, bytes, OFF_W'($urandom_range(0, 65535)));
            end else if (pick < 60) begin
                bytes = ($urandom_range(0, 4) == 0) ? OFF_W'($urandom_range(0, 65535))
                                                    : OFF_W'($urandom_range(0, 2000));
                r = make_req(ACT_SHRINK, bytes,
                             ($urandom_range(0, 9) == 0) ? OFF_W'($urandom_range(0, 65535))
                                                         : newest_payload);
            end else if (pick < 92) begin
                case ($urandom_range(0, 9)) inside
                    0:       r = make_req(ACT_FREE, OFF_W'($urandom_range(0, 65535)),
                                          OFF_W'($urandom_range(0, 65535)));
                    [1:4]:   r = make_req(ACT_FREE, OFF_W'($urandom_range(0, 65535)),
                                          newest_payload);
                    default: r = make_req(ACT_FREE, OFF_W'($urandom_range(0, 65535)),
                                          oldest_payload);
                endcase
            end else begin
                r = make_req(2'($urandom_range(0, 3)), OFF_W'($urandom_range(0, 65535)),
                             OFF_W'($urandom_range(0, 65535)));
            end
            offer(r);
        end

        settle();
        while (live_records != 0) begin
            offer(make_req(ACT_FREE, 16'd0, oldest_payload));
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
